// ----- rtl/hne_pkg.sv -----
// Package for the HTML numeric entity escaper.
// Holds the expanded-sequence type and the character constants; no dependencies.
`default_nettype none

package hne_pkg;

    // Longest expansion: '&', '#', three digits, ';'.
    localparam int SEQ_MAX = 6;
    localparam int LEN_W   = 3;
    localparam int IDX_W   = 3;

    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [3:0] DIGIT_HI  = 4'h3;

    typedef logic [7:0] char_t;

    // One input byte after expansion: output bytes in order, their count
    // and the end-of-string flag to place on the final byte.
    typedef struct packed {
        char_t [SEQ_MAX-1:0] chars;
        logic  [LEN_W-1:0]   len;
        logic                str_end;
    } seq_t;

    // Membership in the fixed escape set: tab, newline, space and the
    // ASCII punctuation characters.
    function automatic logic in_escape_set(input char_t v);
        logic hit;
        begin
            hit = (v == 8'd9) || (v == 8'd10)
               || (v >= 8'd32 && v <= 8'd47)
               || (v >= 8'd58 && v <= 8'd64)
               || (v >= 8'd91 && v <= 8'd96)
               || (v >= 8'd123 && v <= 8'd126);
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hne_if.sv -----
// Valid/ready stream interfaces for the escaper's input and output channels.
// No dependencies.
`default_nettype none

interface hne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_end;

    modport source (output valid, output text_byte, output string_end, input ready);
    modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface hne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_string_end;

    modport source (output valid, output out_byte, output run_last,
                    output out_string_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input out_string_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/hne_expand.sv -----
// Combinational expansion of one text byte into its output byte sequence.
// Depends on hne_pkg.
`default_nettype none

module hne_expand (
    input  wire logic [7:0]    text_byte,
    input  wire logic          string_end,
    output hne_pkg::seq_t      seq
);
    import hne_pkg::*;

    logic        escape;
    logic        hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones_w;
    logic [3:0]  ones;
    logic [1:0]  ndig;

    // Decimal digits; only set members (below 128) matter here.
    always_comb
    begin
        escape = in_escape_set(text_byte);
        hund   = (text_byte >= 8'd100);
        rem    = 7'(text_byte - (hund ? 8'd100 : 8'd0));
        // Divide by ten via reciprocal, exact for values below 100.
        prod   = 15'(rem) * 15'd205;
        tens   = prod[14:11];
        ones_w = rem - 7'(tens) * 7'd10;
        ones   = ones_w[3:0];
        if (hund)
            ndig = 2'd3;
        else if (text_byte >= 8'd10)
            ndig = 2'd2;
        else
            ndig = 2'd1;
    end

    // Assemble the sequence.
    always_comb
    begin
        seq.chars   = '0;
        seq.str_end = string_end;
        if (escape)
        begin
            seq.chars[0] = CHAR_AMP;
            seq.chars[1] = CHAR_HASH;
            seq.len      = LEN_W'(3) + LEN_W'(ndig);
            case (ndig)
                2'd1:
                begin
                    seq.chars[2] = {DIGIT_HI, ones};
                    seq.chars[3] = CHAR_SEMI;
                end
                2'd2:
                begin
                    seq.chars[2] = {DIGIT_HI, tens};
                    seq.chars[3] = {DIGIT_HI, ones};
                    seq.chars[4] = CHAR_SEMI;
                end
                default:
                begin
                    seq.chars[2] = CHAR_ONE;
                    seq.chars[3] = {DIGIT_HI, tens};
                    seq.chars[4] = {DIGIT_HI, ones};
                    seq.chars[5] = CHAR_SEMI;
                end
            endcase
        end
        else
        begin
            seq.chars[0] = text_byte;
            seq.len      = LEN_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hne_emit.sv -----
// Sequence register and output register: plays out one expanded sequence
// a byte per beat. Depends on hne_pkg.
`default_nettype none

module hne_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire hne_pkg::seq_t seq,
    output logic               can_load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               out_string_end
);
    import hne_pkg::*;

    seq_t             seq_reg;
    logic             seq_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;
    logic             out_end_reg;

    logic             out_load;
    logic             is_last;
    logic             seq_done;

    // Move a byte forward when the output register is free or draining.
    assign out_load = seq_valid_reg && (!out_valid_reg || out_ready);
    assign is_last  = (idx_reg == IDX_W'(seq_reg.len - LEN_W'(1)));
    assign seq_done = out_load && is_last;
    assign can_load = !seq_valid_reg || seq_done;

    // Sequence register and byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                seq_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (seq_done)
            begin
                seq_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (out_load)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            seq_reg <= seq;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= seq_reg.chars[idx_reg];
            run_last_reg <= is_last;
            out_end_reg  <= is_last && seq_reg.str_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign run_last       = run_last_reg;
    assign out_string_end = out_end_reg;

endmodule

`default_nettype wire

// ----- rtl/html_numeric_entity_escaper.sv -----
// Top level of the HTML numeric entity escaper.
// Depends on hne_pkg, hne_if, hne_expand and hne_emit.
//
//   Channel    Dir  Beat payload
//   text_in    in   text_byte[7:0], string_end
//   text_out   out  out_byte[7:0], run_last, out_string_end
//
// A byte outside the escape set emits one output byte; an escaped byte emits
// four to six bytes, played out one per beat by the sequence register
// that holds its entity. The first output byte passes through the sequence
// register and then the output register after its input beat is accepted.
// A new byte is taken in the cycle its predecessor's last byte moves to
// the output register, so pass-through text flows at one beat per cycle
// while the output is not stalled. Reset clears the valid flags and the byte
// index; output stalls hold the output register and, through it, the input.
`default_nettype none

module html_numeric_entity_escaper (
    input wire logic clk,
    input wire logic rst_n,
    hne_in_if.sink   text_in,
    hne_out_if.source text_out
);
    import hne_pkg::*;

    seq_t seq;
    logic can_load;
    logic load;

    hne_expand u_expand (
        .text_byte  (text_in.text_byte),
        .string_end (text_in.string_end),
        .seq        (seq)
    );

    // Accept a beat whenever the sequence register frees up.
    assign text_in.ready = can_load;
    assign load          = text_in.valid && can_load;

    hne_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .seq            (seq),
        .can_load       (can_load),
        .out_valid      (text_out.valid),
        .out_ready      (text_out.ready),
        .out_byte       (text_out.out_byte),
        .run_last       (text_out.run_last),
        .out_string_end (text_out.out_string_end)
    );

endmodule

`default_nettype wire
